/* hdl/hta_pkg.sv */
// Shared types, constants and the sRGB threshold table builder for the tonemap/crop core.
package hta_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_DIM = 16384;
   localparam int DIM_W = 15;
   localparam int CH_W = 23;
   localparam int POS_W = 14;
   localparam int Q_W = FRAC_BITS + 1;
   localparam int XX_W = 2 * CH_W;
   localparam int NUM_W = XX_W + 10;
   localparam int R_W = NUM_W + 1;
   localparam int QUEUE_DEPTH = 2;
   // floor(x/9) == (x*DIV9_RECIP) >> 16 for every 15-bit x
   localparam int DIV9_RECIP = 7282;

   typedef enum logic [1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_PORTRAIT = 2'd2,
      CSR_HDR      = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SQ,
      B_MUL,
      B_CMP,
      B_DIV,
      B_RND,
      B_CODE,
      B_OUT
   } bstate_type;

   typedef struct packed {
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
      logic [2:0]      nonfinite_mask;
   } req_type;

   typedef struct packed {
      logic [7:0]       red_out;
      logic [7:0]       green_out;
      logic [7:0]       blue_out;
      logic [POS_W-1:0] out_col;
      logic [POS_W-1:0] out_row;
      logic             last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [2:0][CH_W-1:0] chan;
      logic [2:0]           mask;
      logic [POS_W-1:0]     col;
      logic [POS_W-1:0]     row;
      logic                 last;
   } item_type;

   typedef logic [Q_W-1:0] thr_tab_type [256];

   function automatic longint unsigned q32mul(longint unsigned a, longint unsigned b);
      longint unsigned p;
      p = a * b;
      return p >> 32;
   endfunction

   function automatic longint unsigned fifth_pow(longint unsigned r);
      longint unsigned p;
      p = q32mul(r, r);
      p = q32mul(p, r);
      p = q32mul(p, r);
      return q32mul(p, r);
   endfunction

   // Q.F ceiling of the linear value where each sRGB code step begins
   function automatic thr_tab_type thr_build();
      thr_tab_type t;
      longint unsigned n, a, u2, lo, hi, mid, v;
      t[0] = '0;
      for (int k = 1; k < 256; k++) begin
         if (k <= 10) begin
            n = longint'(((2 * k - 1) * 5)) << FRAC_BITS;
            t[k] = Q_W'((n + 64'd32945) / 64'd32946);
         end else begin
            a = (longint'(40 * k + 541) << 32) / 64'd10761;
            u2 = q32mul(a, a);
            lo = 0;
            hi = 64'hFFFF_FFFF;
            while (lo < hi) begin
               mid = lo + (hi - lo + 1) / 2;
               if (fifth_pow(mid) <= u2) lo = mid;
               else hi = mid - 1;
            end
            v = q32mul(u2, lo);
            t[k] = Q_W'((v + ((64'd1 << (32 - FRAC_BITS)) - 1)) >> (32 - FRAC_BITS));
         end
      end
      return t;
   endfunction

endpackage

/* hdl/hta_front.sv */
// Front end: window placement, frame position counters and crop classification.
module hta_front
   import hta_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] frame_width,
   input  logic [DIM_W-1:0] frame_height,
   input  logic             portrait,
   input  logic             geo_wr,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic             q_full,
   output logic             push,
   output item_type         push_item
);

   logic [DIM_W-1:0] left_ff, top_ff, ww_ff, wh_ff;
   logic [DIM_W-1:0] left_in, top_in, ww_in, wh_in;
   logic [DIM_W-1:0] col_ff, row_ff, col_in, row_in;
   logic             settle_ff;
   logic             bad;
   logic [DIM_W-1:0] w9, h9, uw, uh, unit;
   logic [DIM_W+15:0] pw, ph;
   logic [DIM_W+3:0] ww_w, wh_w;
   logic             accept, in_win;
   logic [DIM_W:0]   col_x, row_x;
   logic [DIM_W-1:0] c_off, r_off;

   always_comb begin
      bad = (frame_width < DIM_W'(16)) || (frame_height < DIM_W'(16)) ||
            (frame_width > DIM_W'(MAX_DIM)) || (frame_height > DIM_W'(MAX_DIM));
      pw = (DIM_W+16)'(frame_width) * (DIM_W+16)'(DIV9_RECIP);
      ph = (DIM_W+16)'(frame_height) * (DIM_W+16)'(DIV9_RECIP);
      w9 = pw[DIM_W+15:16];
      h9 = ph[DIM_W+15:16];
      uw = portrait ? w9 : (frame_width >> 4);
      uh = portrait ? (frame_height >> 4) : h9;
      unit = (uh < uw) ? uh : uw;
      ww_w = portrait ? (((DIM_W+4)'(unit) << 3) + (DIM_W+4)'(unit)) : ((DIM_W+4)'(unit) << 4);
      wh_w = portrait ? ((DIM_W+4)'(unit) << 4) : (((DIM_W+4)'(unit) << 3) + (DIM_W+4)'(unit));
      if (bad || unit == '0) begin
         ww_in = '0;
         wh_in = '0;
         left_in = '0;
         top_in = '0;
      end else begin
         ww_in = ww_w[DIM_W-1:0];
         wh_in = wh_w[DIM_W-1:0];
         left_in = (frame_width - ww_w[DIM_W-1:0]) >> 1;
         top_in = (frame_height - wh_w[DIM_W-1:0]) >> 1;
      end
   end

   assign req_ready = settle_ff && !q_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      in_win = (col_ff >= left_ff) &&
               ((DIM_W+1)'(col_ff) < (DIM_W+1)'(left_ff) + (DIM_W+1)'(ww_ff)) &&
               (row_ff >= top_ff) &&
               ((DIM_W+1)'(row_ff) < (DIM_W+1)'(top_ff) + (DIM_W+1)'(wh_ff));
      c_off = col_ff - left_ff;
      r_off = row_ff - top_ff;
      col_x = (DIM_W+1)'(col_ff) + 1'b1;
      row_x = (DIM_W+1)'(row_ff) + 1'b1;
      col_in = col_ff;
      row_in = row_ff;
      if (accept && ww_ff != '0) begin
         if (col_x >= (DIM_W+1)'(frame_width)) begin
            col_in = '0;
            row_in = (row_x >= (DIM_W+1)'(frame_height)) ? '0 : row_x[DIM_W-1:0];
         end else begin
            col_in = col_x[DIM_W-1:0];
         end
      end
      push = accept && ww_ff != '0 && in_win;
      push_item.chan[0] = req_data.red_in;
      push_item.chan[1] = req_data.green_in;
      push_item.chan[2] = req_data.blue_in;
      push_item.mask = req_data.nonfinite_mask;
      push_item.col = c_off[POS_W-1:0];
      push_item.row = r_off[POS_W-1:0];
      push_item.last = ((DIM_W+1)'(c_off) + 1'b1 == (DIM_W+1)'(ww_ff)) &&
                       ((DIM_W+1)'(r_off) + 1'b1 == (DIM_W+1)'(wh_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         top_ff <= '0;
         ww_ff <= '0;
         wh_ff <= '0;
      end else begin
         // window regs follow the config in the next cycle; hold off requests meanwhile
         settle_ff <= !geo_wr;
         left_ff <= left_in;
         top_ff <= top_in;
         ww_ff <= ww_in;
         wh_ff <= wh_in;
         if (geo_wr) begin
            col_ff <= '0;
            row_ff <= '0;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

/* hdl/hta_queue.sv */
// Small FIFO between classification and the tonemap engine.
module hta_queue
   import hta_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     full,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wp_ff, rp_ff;
   logic [CW-1:0]   cnt_ff;

   assign full = cnt_ff == CW'(DEPTH);
   assign empty = cnt_ff == '0;
   assign pop_item = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

/* hdl/hta_back.sv */
// Back end: ACES filmic curve (restoring division), sRGB search or SDR low byte
module hta_back
   import hta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     hdr_mode,
   input  logic     q_empty,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam thr_tab_type THR = thr_build();
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CH_W-1:0] TOP = CH_W'(100) << FRAC_BITS;
   localparam logic [NUM_W-1:0] DEN_C = NUM_W'(14) << (2 * FRAC_BITS);

   bstate_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [2:0]       step_ff;
   logic [CH_W-1:0]  x_ff [3];
   logic [XX_W-1:0]  xx_ff [3];
   logic [XX_W-1:0]  xo_ff [3];
   logic [NUM_W-1:0] num_ff [3];
   logic [NUM_W-1:0] den_ff [3];
   logic [R_W-1:0]   r_ff [3];
   logic [Q_W-1:0]   q_ff [3];
   logic [Q_W-1:0]   y_ff [3];
   logic             sat_ff [3];
   logic [7:0]       code_ff [3];
   logic [7:0]       sdr_ff [3];
   logic [POS_W-1:0] col_ff, row_ff;
   logic             last_ff, hdr_ff;
   logic [R_W-1:0]   r2 [3];
   logic [7:0]       cand [3];
   logic [Q_W:0]     qr [3];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (!q_empty) state_in = B_SQ;
         B_SQ:   state_in = B_MUL;
         B_MUL:  state_in = B_CMP;
         B_CMP:  state_in = B_DIV;
         B_DIV:  if (cnt_ff == CNT_W'(FRAC_BITS)) state_in = B_RND;
         B_RND:  state_in = B_CODE;
         B_CODE: if (step_ff == 3'd7) state_in = B_OUT;
         B_OUT:  if (rsp_ready) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop = (state_ff == B_IDLE) && !q_empty;
      rsp_valid = (state_ff == B_OUT);
      rsp_data.red_out = hdr_ff ? code_ff[0] : sdr_ff[0];
      rsp_data.green_out = hdr_ff ? code_ff[1] : sdr_ff[1];
      rsp_data.blue_out = hdr_ff ? code_ff[2] : sdr_ff[2];
      rsp_data.out_col = col_ff;
      rsp_data.out_row = row_ff;
      rsp_data.last_pixel = last_ff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r2[i] = r_ff[i] << 1;
         cand[i] = code_ff[i] | (8'h80 >> step_ff);
         qr[i] = (Q_W+1)'(q_ff[i]) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= (state_ff == B_DIV) ? cnt_ff + 1'b1 : '0;
         step_ff <= (state_ff == B_CODE) ? step_ff + 1'b1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            hdr_ff <= hdr_mode;
            col_ff <= q_item.col;
            row_ff <= q_item.row;
            last_ff <= q_item.last;
            for (int i = 0; i < 3; i++) begin
               sdr_ff[i] <= q_item.chan[i][7:0];
               if (q_item.mask[i]) x_ff[i] <= '0;
               else x_ff[i] <= (q_item.chan[i] > TOP) ? TOP : q_item.chan[i];
            end
         end
         B_SQ: begin
            for (int i = 0; i < 3; i++) begin
               xx_ff[i] <= XX_W'(x_ff[i]) * XX_W'(x_ff[i]);
               xo_ff[i] <= XX_W'(x_ff[i]) << FRAC_BITS;
            end
         end
         B_MUL: begin
            for (int i = 0; i < 3; i++) begin
               num_ff[i] <= NUM_W'(xx_ff[i]) * NUM_W'(251) + NUM_W'(xo_ff[i]) * NUM_W'(3);
               den_ff[i] <= NUM_W'(xx_ff[i]) * NUM_W'(243) + NUM_W'(xo_ff[i]) * NUM_W'(59)
                            + DEN_C;
            end
         end
         B_CMP: begin
            for (int i = 0; i < 3; i++) begin
               sat_ff[i] <= num_ff[i] >= den_ff[i];
               r_ff[i] <= R_W'(num_ff[i]);
               q_ff[i] <= '0;
            end
         end
         B_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (r2[i] >= R_W'(den_ff[i])) begin
                  r_ff[i] <= r2[i] - R_W'(den_ff[i]);
                  q_ff[i] <= {q_ff[i][Q_W-2:0], 1'b1};
               end else begin
                  r_ff[i] <= r2[i];
                  q_ff[i] <= {q_ff[i][Q_W-2:0], 1'b0};
               end
            end
         end
         B_RND: begin
            for (int i = 0; i < 3; i++) begin
               y_ff[i] <= sat_ff[i] ? (Q_W'(1) << FRAC_BITS) : qr[i][Q_W:1];
               code_ff[i] <= '0;
            end
         end
         B_CODE: begin
            // thresholds rise with the code, so a bitwise search finds the count
            for (int i = 0; i < 3; i++) begin
               if (THR[cand[i]] <= y_ff[i]) code_ff[i] <= cand[i];
            end
         end
         default: ;
      endcase
   end

endmodule

/* hdl/hdr_tonemap_aspect_crop_core.sv */
// Top level: register file plus front end, queue and tonemap back end.
//
//  port group   direction  handshake        payload
//  req_*        in         valid / ready    req_type (RGB Q7.16, nonfinite mask)
//  rsp_*        out        valid / ready    rsp_type (sRGB bytes, window position, last)
//  csr_*        in         write enable     2-bit index, 15-bit data
//
// Pixels outside the window are dropped in the front end; requests still stall
// on a full queue. The back end takes each pixel in the window through load,
// square, multiply, compare, restoring divide, round, code search and output
// before taking the next. A two-entry queue lets the front keep accepting while
// the back end works. Synchronous reset; requests are held off after reset and
// after each geometry write while the window is recomputed.
module hdr_tonemap_aspect_crop_core
   import hta_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_idx,
   input  logic [DIM_W-1:0] csr_data
);

   logic [DIM_W-1:0] fw_ff, fh_ff;
   logic             portrait_ff, hdr_ff;
   logic             geo_wr;
   logic             push, pop, q_full, q_empty;
   item_type         push_item, pop_item;

   always_comb begin
      geo_wr = 1'b0;
      if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_WIDTH, CSR_HEIGHT, CSR_PORTRAIT: geo_wr = 1'b1;
            default: geo_wr = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= DIM_W'(1920);
         fh_ff <= DIM_W'(1080);
         portrait_ff <= 1'b0;
         hdr_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_WIDTH:    fw_ff <= csr_data;
            CSR_HEIGHT:   fh_ff <= csr_data;
            CSR_PORTRAIT: portrait_ff <= csr_data[0];
            CSR_HDR:      hdr_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   hta_front u_front (
      .clock(clock), .reset(reset),
      .frame_width(fw_ff), .frame_height(fh_ff), .portrait(portrait_ff), .geo_wr(geo_wr),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_full(q_full), .push(push), .push_item(push_item)
   );

   hta_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_item(push_item), .pop(pop), .pop_item(pop_item),
      .full(q_full), .empty(q_empty)
   );

   hta_back u_back (
      .clock(clock), .reset(reset), .hdr_mode(hdr_ff),
      .q_empty(q_empty), .q_item(pop_item), .q_pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

/* hdl/hta_checker.sv */
// Port-level checks for the tonemap/crop core, bound to the top level.
module hta_checker
   import hta_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input req_type          req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data,
   input logic             csr_we,
   input logic [1:0]       csr_idx
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   a_geo_hold: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_idx == CSR_WIDTH || csr_idx == CSR_HEIGHT || csr_idx == CSR_PORTRAIT)
      |=> !req_ready)
      else $error("request taken while window recomputes");

   a_no_back2back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response repeated without new work");

endmodule

bind hdr_tonemap_aspect_crop_core hta_checker u_hta_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
   .csr_we(csr_we), .csr_idx(csr_idx)
);

/* test/hdr_tonemap_aspect_crop_core_test.sv */
// Testbench for the HDR tonemap and aspect crop core: predicted results vs. DUT output.
`timescale 1ns / 1ps

module hdr_tonemap_aspect_crop_core_test;
   import hta_pkg::*;

   class crop_scoreboard;
      longint unsigned srgb_step [256];
      int unsigned width_px, height_px, win_left, win_top, win_w, win_h, col_n, row_n;
      bit portrait_on, hdr_on;
      rsp_type pending_px [$];
      int errors;

      function new();
         longint unsigned lin, num, lo, hi, mid, u2;
         srgb_step[0] = 0;
         for (int k = 1; k < 256; k++) begin
            if (k <= 10) begin
               num = longint'((2 * k - 1) * 5) << FRAC_BITS;
               srgb_step[k] = (num + 32945) / 32946;
            end else begin
               lin = (longint'(40 * k + 541) << 32) / 10761;
               u2 = (lin * lin) >> 32;
               lo = 0;
               hi = 64'hFFFF_FFFF;
               // largest Q32 r with r^5 <= u^2, so that u^2.4 = u^2 * r
               while (lo < hi) begin
                  mid = lo + (hi - lo + 1) / 2;
                  if (pow5_q32(mid) <= u2) lo = mid;
                  else hi = mid - 1;
               end
               num = (u2 * lo) >> 32;
               srgb_step[k] = (num + ((64'd1 << (32 - FRAC_BITS)) - 1)) >> (32 - FRAC_BITS);
            end
         end
         width_px = 1920;
         height_px = 1080;
         portrait_on = 0;
         hdr_on = 1;
         errors = 0;
         place();
      endfunction

      function longint unsigned pow5_q32(longint unsigned r);
         longint unsigned p;
         p = (r * r) >> 32;
         p = (p * r) >> 32;
         p = (p * r) >> 32;
         return (p * r) >> 32;
      endfunction

      function void place();
         int unsigned ax, ay, unit;
         ax = portrait_on ? 9 : 16;
         ay = portrait_on ? 16 : 9;
         col_n = 0;
         row_n = 0;
         win_left = 0;
         win_top = 0;
         win_w = 0;
         win_h = 0;
         if (width_px < 16 || height_px < 16 || width_px > MAX_DIM || height_px > MAX_DIM)
            return;
         unit = width_px / ax;
         if (height_px / ay < unit) unit = height_px / ay;
         if (unit == 0) return;
         win_w = unit * ax;
         win_h = unit * ay;
         win_left = (width_px - win_w) / 2;
         win_top = (height_px - win_h) / 2;
      endfunction

      function void write_reg(csr_idx_type idx, int unsigned val);
         case (idx)
            CSR_WIDTH: begin
               width_px = val & 16'h7FFF;
               place();
            end
            CSR_HEIGHT: begin
               height_px = val & 16'h7FFF;
               place();
            end
            CSR_PORTRAIT: begin
               portrait_on = val[0];
               place();
            end
            CSR_HDR: hdr_on = val[0];
            default: ;
         endcase
      endfunction

      function logic [7:0] encode(logic [CH_W-1:0] v, bit bad);
         longint unsigned x, num, den, r, q, y;
         int code;
         if (!hdr_on) return v[7:0];
         x = bad ? 0 : v;
         if (x > (100 << FRAC_BITS)) x = 100 << FRAC_BITS;
         num = 251 * x * x + 3 * x * (1 << FRAC_BITS);
         den = 243 * x * x + 59 * x * (1 << FRAC_BITS) + (64'd14 << (2 * FRAC_BITS));
         if (num >= den) begin
            y = 1 << FRAC_BITS;
         end else begin
            r = num;
            q = 0;
            for (int i = 0; i <= FRAC_BITS; i++) begin
               r = r << 1;
               q = q << 1;
               if (r >= den) begin
                  r -= den;
                  q |= 1;
               end
            end
            y = (q + 1) >> 1;
         end
         code = 0;
         for (int k = 1; k < 256; k++)
            if (y >= srgb_step[k]) code++;
         return code[7:0];
      endfunction

      function void note_pixel(req_type px);
         rsp_type e;
         int unsigned c, r;
         if (win_w == 0) return;
         if (col_n >= win_left && col_n < win_left + win_w &&
             row_n >= win_top && row_n < win_top + win_h) begin
            c = col_n - win_left;
            r = row_n - win_top;
            e.red_out = encode(px.red_in, px.nonfinite_mask[0]);
            e.green_out = encode(px.green_in, px.nonfinite_mask[1]);
            e.blue_out = encode(px.blue_in, px.nonfinite_mask[2]);
            e.out_col = c[POS_W-1:0];
            e.out_row = r[POS_W-1:0];
            e.last_pixel = (c + 1 == win_w && r + 1 == win_h);
            pending_px.push_back(e);
         end
         col_n++;
         if (col_n >= width_px) begin
            col_n = 0;
            row_n++;
            if (row_n >= height_px) row_n = 0;
         end
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check_pixel(rsp_type got);
         rsp_type e;
         if (pending_px.size() == 0) begin
            report("unexpected pixel, row", got.out_row, 0);
            return;
         end
         e = pending_px.pop_front();
         if (got.red_out !== e.red_out) report("red", got.red_out, e.red_out);
         if (got.green_out !== e.green_out) report("green", got.green_out, e.green_out);
         if (got.blue_out !== e.blue_out) report("blue", got.blue_out, e.blue_out);
         if (got.out_col !== e.out_col) report("col", got.out_col, e.out_col);
         if (got.out_row !== e.out_row) report("row", got.out_row, e.out_row);
         if (got.last_pixel !== e.last_pixel) report("last", got.last_pixel, e.last_pixel);
      endtask
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_we;
   req_type req_data;
   rsp_type rsp_data;
   logic [1:0] csr_idx;
   logic [DIM_W-1:0] csr_data;

   crop_scoreboard sb = new();
   int send_idle = 18, recv_idle = 47, hold_left = 0, sent = 0;

   hdr_tonemap_aspect_crop_core uut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
      if (!reset && rsp_valid && rsp_ready) sb.check_pixel(rsp_data);
   end

   task automatic send_pixel(req_type px);
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(px);
      sent++;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_px.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int unsigned val);
      drain();
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_data <= val[DIM_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   function automatic logic [CH_W-1:0] rand_chan();
      case ($urandom_range(3))
         0: return CH_W'($urandom_range(0, 2 << FRAC_BITS));
         1: return CH_W'($urandom_range(0, 1 << 12));
         2: return CH_W'($urandom_range(90 << FRAC_BITS, 110 << FRAC_BITS));
         default: return CH_W'($urandom);
      endcase
   endfunction

   function automatic req_type rand_pixel();
      req_type px;
      px.red_in = rand_chan();
      px.green_in = rand_chan();
      px.blue_in = rand_chan();
      px.nonfinite_mask = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd0;
      return px;
   endfunction

   task automatic send_chans(int unsigned r, int unsigned g, int unsigned b, int unsigned m);
      send_pixel('{red_in: CH_W'(r), green_in: CH_W'(g), blue_in: CH_W'(b),
                   nonfinite_mask: 3'(m)});
   endtask

   task automatic send_random(int n);
      repeat (n) send_pixel(rand_pixel());
   endtask

   initial begin
      int w, h, n;
      bit stalled;
      stalled = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_idx <= CSR_WIDTH;
      csr_data <= '0;
      rsp_ready <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: 1920x1080 is all window
      send_chans(0, 1 << FRAC_BITS, 100 << FRAC_BITS, 0);
      send_chans(23'h7FFFFF, 1, 11796, 0);
      send_chans(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 7);
      send_chans(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 1);
      send_chans(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 2);
      send_chans(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 4);
      send_chans(10, 20, 40, 0);
      send_chans((100 << FRAC_BITS) + 1, 23'h555555, 23'h2AAAAA, 0);
      send_chans(3 << FRAC_BITS, 1 << (FRAC_BITS - 1), 200, 0);
      write_reg(CSR_HDR, 0);
      send_chans(23'h7FFFFF, 23'h123456, 23'h0000FF, 7);
      send_chans(23'h000100, 0, 23'h2AAA80, 0);
      write_reg(CSR_HDR, 1);

      // one whole small frame so the window wraps and flags its last pixel
      write_reg(CSR_WIDTH, 16);
      write_reg(CSR_HEIGHT, 16);
      send_random(256 + 5);
      write_reg(CSR_PORTRAIT, 1);
      send_random(256);
      write_reg(CSR_PORTRAIT, 0);

      // bad and extreme sizes
      write_reg(CSR_WIDTH, 15);
      send_random(4);
      write_reg(CSR_WIDTH, 16385);
      send_random(4);
      write_reg(CSR_WIDTH, 0);
      send_random(4);
      write_reg(CSR_WIDTH, 16384);
      send_random(20);
      write_reg(CSR_HEIGHT, 32767);
      send_random(4);
      write_reg(CSR_WIDTH, 16);
      write_reg(CSR_HEIGHT, 16384);
      send_random(20);
      write_reg(CSR_PORTRAIT, 1);
      send_random(4);

      while (sent < 1450) begin
         w = $urandom_range(16, 30);
         h = $urandom_range(16, 30);
         write_reg(CSR_WIDTH, w);
         write_reg(CSR_HEIGHT, h);
         write_reg(CSR_PORTRAIT, $urandom_range(1));
         write_reg(CSR_HDR, ($urandom_range(3) != 0));
         if (sent >= 1000) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (sent >= 550) begin
            send_idle = 47;
            recv_idle = 18;
         end
         if (!stalled) begin
            // long receiver stall while requests keep coming
            hold_left = 500;
            stalled = 1'b1;
         end
         n = w * h + $urandom_range(0, 40);
         if (n > 1450 - sent) n = 1450 - sent;
         send_random(n);
      end
      drain();
      if (sb.errors == 0)
         $display("hdr_tonemap_aspect_crop_core_test: done, clean");
      else
         $display("hdr_tonemap_aspect_crop_core_test: done, errors");
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("hdr_tonemap_aspect_crop_core_test: done, errors");
      $finish;
   end

endmodule
